>>> sv/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the count-min sketch counter.
// ----------------------------------------------------------------------------
package cms_pkg;

    // Default geometry, used as the top level parameter defaults
    localparam int SLICE_BITS_DEF = 14;
    localparam int ROWS_DEF       = 4;

    // Fixed field widths
    localparam int HASH_W    = 64;
    localparam int COUNT_W   = 8;
    localparam int NUM_WORDS = 4;

    // Saturation value of one counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Output queue geometry
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    typedef logic [HASH_W-1:0]  t_hash;
    typedef logic [COUNT_W-1:0] t_count;

    // Per-cycle control from the top level to each lane
    typedef struct packed {
        logic clear;   // clearing sweep writes zero at the lane address
        logic update;  // a transaction sits in the update stage
    } t_lane_req;

endpackage

>>> sv/cms_in_if.sv
// ----------------------------------------------------------------------------
// cms_in_if
// Input channel: four hash words per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cms_in_if import cms_pkg::*; ();
    logic  valid;
    logic  ready;
    t_hash hash_word_0;
    t_hash hash_word_1;
    t_hash hash_word_2;
    t_hash hash_word_3;

    modport source (
        output valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
        input  ready
    );
    modport sink (
        input  valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
        output ready
    );
endinterface

>>> sv/cms_out_if.sv
// ----------------------------------------------------------------------------
// cms_out_if
// Result channel: estimated count and threshold flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cms_out_if import cms_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count estimated_count;
    logic   above_threshold;

    modport source (
        output valid, estimated_count, above_threshold,
        input  ready
    );
    modport sink (
        input  valid, estimated_count, above_threshold,
        output ready
    );
endinterface

>>> sv/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents before a write in the same cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cms_lane.sv
// ----------------------------------------------------------------------------
// cms_lane
// One sketch row: counter RAM, write-to-read forwarding, saturating update.
// ----------------------------------------------------------------------------
module cms_lane import cms_pkg::*; #(
    parameter int SLICE_BITS = SLICE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_req             i_req,
    input  logic [SLICE_BITS-1:0] i_addr,
    output t_count                o_val
);

    localparam int DEPTH = 2 ** SLICE_BITS;

    logic [SLICE_BITS-1:0] r_addr;
    logic                  r_fwd_v;
    logic [SLICE_BITS-1:0] r_fwd_addr;
    t_count                r_fwd_data;
    t_count                r_val;

    t_count                w_rdata;
    t_count                w_base;
    t_count                n_val;
    logic                  w_we;
    logic [SLICE_BITS-1:0] w_waddr;
    t_count                w_wdata;

    cms_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    // Latest value: the write issued alongside our read is not in the RAM data
    always_comb begin
        w_base = (r_fwd_v && (r_fwd_addr == r_addr)) ? r_fwd_data : w_rdata;
        n_val  = (w_base == COUNT_MAX) ? w_base : w_base + t_count'(1);
    end

    // Write port: clearing sweep or counter update
    assign w_we    = i_req.clear | i_req.update;
    assign w_waddr = i_req.clear ? i_addr : r_addr;
    assign w_wdata = i_req.clear ? '0 : n_val;

    // Forwarding register tracks the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else begin
            r_fwd_v <= w_we;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= i_addr;
        r_fwd_addr <= w_waddr;
        r_fwd_data <= w_wdata;
        if (i_req.update) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

>>> sv/cms_merge.sv
// ----------------------------------------------------------------------------
// cms_merge
// Minimum across lanes, threshold compare, and the output queue.
// ----------------------------------------------------------------------------
module cms_merge import cms_pkg::*; #(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_count               i_vals [ROWS],
    input  t_count               i_threshold,
    output logic [OUT_LVL_W-1:0] o_level,
    cms_out_if.source            o_out
);

    t_count                r_q_cnt  [OUT_DEPTH];
    logic                  r_q_flag [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr_ptr;
    logic [OUT_PTR_W-1:0]  r_rd_ptr;
    logic [OUT_LVL_W-1:0]  r_level;

    t_count                w_least;
    logic                  w_pop;

    // Minimum over the lanes
    always_comb begin
        w_least = COUNT_MAX;
        for (int r = 0; r < ROWS; r++) begin
            if (i_vals[r] < w_least) begin
                w_least = i_vals[r];
            end
        end
    end

    assign w_pop = o_out.valid & o_out.ready;

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_valid) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            case ({i_valid, w_pop})
                2'b10:   r_level <= r_level + OUT_LVL_W'(1);
                2'b01:   r_level <= r_level - OUT_LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q_cnt[r_wr_ptr]  <= w_least;
            r_q_flag[r_wr_ptr] <= (w_least > i_threshold);
        end
    end

    assign o_out.valid           = (r_level != '0);
    assign o_out.estimated_count = r_q_cnt[r_rd_ptr];
    assign o_out.above_threshold = r_q_flag[r_rd_ptr];
    assign o_level               = r_level;

endmodule

>>> sv/count_min_sketch_counter.sv
// ----------------------------------------------------------------------------
// count_min_sketch_counter
// Count-min sketch of 8-bit saturating counters, one lane per row.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries four 64-bit hash words per transaction. Word w feeds rows
//   2w (low slice) and 2w+1 (next slice); only the first ROWS rows exist.
//   o_out returns one transaction per input: the minimum of the updated
//   counters and a flag set when it exceeds the threshold register.
//   i_cfg_we / i_cfg_wdata write the threshold; write it only while idle.
// Pipeline: RAM read, update and write-back, lane minimum into output queue.
// Throughput: one transaction per cycle while the output queue has room.
//   Each row RAM does one read and one write per cycle; back-to-back hits
//   on the same counter are forwarded.
// Reset: i_rst_n is synchronous, active low. After reset a clearing sweep
//   zeroes all rows, one address per cycle; i_in is not ready during the
//   sweep. Threshold writes are taken throughout.
// Stall: a 4-entry output queue absorbs results; i_in.ready drops once the
//   items in flight plus queued results fill it, so nothing is lost.
// ----------------------------------------------------------------------------
module count_min_sketch_counter import cms_pkg::*; #(
    parameter int SLICE_BITS = SLICE_BITS_DEF,
    parameter int ROWS       = ROWS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  t_count       i_cfg_wdata,
    cms_in_if.sink       i_in,
    cms_out_if.source    o_out
);

    logic                  r_clr;
    logic [SLICE_BITS-1:0] r_sweep;
    logic                  r_v1;
    logic                  r_v2;
    t_count                r_threshold;

    t_hash                 w_words [NUM_WORDS];
    t_count                w_vals  [ROWS];
    logic [OUT_LVL_W-1:0]  w_level;
    logic [OUT_LVL_W:0]    w_busy;
    logic                  w_accept;
    t_lane_req             w_req;

    assign w_words[0] = i_in.hash_word_0;
    assign w_words[1] = i_in.hash_word_1;
    assign w_words[2] = i_in.hash_word_2;
    assign w_words[3] = i_in.hash_word_3;

    // Credit check: in-flight items plus queued results must fit the queue
    assign w_busy = (OUT_LVL_W+1)'(w_level) + (OUT_LVL_W+1)'(r_v1)
                  + (OUT_LVL_W+1)'(r_v2);
    assign i_in.ready = !r_clr && (w_busy < (OUT_LVL_W+1)'(OUT_DEPTH));
    assign w_accept   = i_in.valid & i_in.ready;

    assign w_req.clear  = r_clr;
    assign w_req.update = r_v1;

    // Clearing sweep and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_sweep <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            if (r_clr) begin
                r_sweep <= r_sweep + SLICE_BITS'(1);
                if (r_sweep == {SLICE_BITS{1'b1}}) begin
                    r_clr <= 1'b0;
                end
            end
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // One lane per row
    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        localparam int WORD  = r / 2;
        localparam int SLICE = r % 2;

        logic [SLICE_BITS-1:0] w_addr;

        assign w_addr = r_clr ? r_sweep
                              : w_words[WORD][SLICE*SLICE_BITS +: SLICE_BITS];

        cms_lane #(
            .SLICE_BITS (SLICE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_req),
            .i_addr  (w_addr),
            .o_val   (w_vals[r])
        );
    end

    cms_merge #(
        .ROWS (ROWS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v2),
        .i_vals      (w_vals),
        .i_threshold (r_threshold),
        .o_level     (w_level),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // No transaction is taken while the counters are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !w_accept)
        else $error("input accepted during clearing sweep");

    // Items in flight and queued results never exceed the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy <= (OUT_LVL_W+1)'(OUT_DEPTH))
        else $error("output queue credit overrun");

    // An accepted transaction passes r_v1 and then r_v2 to reach the merge stage
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_v2)
        else $error("accepted transaction lost in pipeline");

    // Updates never coincide with the clearing sweep
    a_no_update_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr && r_v1))
        else $error("counter update during clearing sweep");
`endif

endmodule

>>> tb/sv/count_min_sketch_counter_tb.sv
// ----------------------------------------------------------------------------
// count_min_sketch_counter_tb
// Self-checking bench for the count-min sketch counter. A shadow sketch of
// saturating counters predicts each estimate and threshold flag not fixed
// by the short table of directed hash transactions that runs first, then
// random traffic weighted towards hot keys so counters reach saturation.
// Both channels idle at random, and the threshold is rewritten between phases.
// ----------------------------------------------------------------------------
module count_min_sketch_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cms_pkg::*;

    localparam int SL_BITS     = SLICE_BITS_DEF;
    localparam int ROWS_N      = ROWS_DEF;
    localparam int ROW_DEPTH   = 1 << SL_BITS;
    localparam int PROBE_N     = 16;
    localparam int SEG_N       = 6;
    localparam int SEG_ITEMS   = 272;
    localparam int HOLD_CYCLES = 48;
    localparam int HOT_KEYS    = 4;
    localparam int PREDICT     = -1;
    localparam int SETTLE_CYC  = 4;
    localparam longint LIMIT_NS = 2_000_000;

    // Hash word patterns used by the directed table
    localparam t_hash Z       = '0;
    localparam t_hash O       = '1;
    localparam t_hash HI      = 64'hFFFF_FFFF_F000_0000;
    localparam t_hash ROW1TOP = 64'h0000_0000_0FFF_C000;
    localparam t_hash BIT13   = 64'h0000_0000_0000_2000;
    localparam t_hash BIT27   = 64'h0000_0000_0800_0000;
    localparam t_hash FRESH   = 64'h0000_0000_0000_1234;
    localparam t_hash MSB     = 64'h8000_0000_0000_0000;
    localparam t_hash CHK5    = 64'h5555_5555_5555_5555;
    localparam t_hash CHKA    = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef logic [NUM_WORDS-1:0][HASH_W-1:0] t_hash_set;

    typedef struct packed {
        t_count count;
        logic   above;
    } t_estimate;

    typedef struct {
        t_hash_set hashes;
        int        want_count;
        int        want_above;
    } t_probe;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_count i_cfg_wdata;

    cms_in_if  in_if ();
    cms_out_if out_if ();

    count_min_sketch_counter #(
        .SLICE_BITS (SL_BITS),
        .ROWS       (ROWS_N)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow sketch and threshold
    bit [COUNT_W-1:0] sketch_mem [ROWS_N][ROW_DEPTH];
    t_count           model_threshold = '0;
    t_estimate        estimate_q [$];

    logic [SL_BITS-1:0] hot_slot [HOT_KEYS][ROWS_N];
    t_probe             probe_tab [PROBE_N];

    int unsigned send_gap_pct = 0;
    int unsigned take_gap_pct = 0;
    logic        hold_trigger = 1'b0;
    logic        sink_hold    = 1'b0;

    int n_errors    = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_saturated = 0;
    int n_above     = 0;
    int n_settings  = 0;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Bump one counter per row, return the minimum after the update
    function automatic t_count sketch_bump(input t_hash_set hs);
        t_count             least;
        logic [SL_BITS-1:0] slot;
        least = COUNT_MAX;
        for (int r = 0; r < ROWS_N; r++) begin
            slot = hs[r / 2][(r % 2) * SL_BITS +: SL_BITS];
            if (sketch_mem[r][slot] != COUNT_MAX)
                sketch_mem[r][slot] = sketch_mem[r][slot] + 1'b1;
            if (sketch_mem[r][slot] < least)
                least = sketch_mem[r][slot];
        end
        return least;
    endfunction

    // Random hashes: mostly hot keys or clustered slots, rest fully random
    function automatic t_hash_set random_hashes();
        t_hash_set          hs;
        int unsigned        pick;
        int unsigned        key;
        logic [SL_BITS-1:0] slot;
        for (int w = 0; w < NUM_WORDS; w++)
            hs[w] = {$urandom, $urandom};
        pick = $urandom_range(99);
        key  = (pick < 35) ? 0 : $urandom_range(HOT_KEYS - 1);
        if (pick < 70) begin
            for (int r = 0; r < ROWS_N; r++) begin
                if (pick < 50)
                    slot = hot_slot[key][r];
                else
                    slot = SL_BITS'(($urandom_range(1) ? ROW_DEPTH - 4 : 0)
                                    + $urandom_range(3));
                hs[r / 2][(r % 2) * SL_BITS +: SL_BITS] = slot;
            end
        end
        return hs;
    endfunction

    // Offer one transaction; predict its estimate once accepted
    task automatic offer(input t_hash_set hs, input int want_count, input int want_above);
        t_estimate est;
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.hash_word_0 <= hs[0];
        in_if.hash_word_1 <= hs[1];
        in_if.hash_word_2 <= hs[2];
        in_if.hash_word_3 <= hs[3];
        do @(posedge i_clk); while (!in_if.ready);
        est.count = sketch_bump(hs);
        est.above = est.count > model_threshold;
        if (want_count != PREDICT) begin
            est.count = t_count'(want_count);
            est.above = want_above[0];
        end
        estimate_q.push_back(est);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        in_if.valid <= 1'b0;
        while (estimate_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic set_threshold(input t_count thr);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(negedge i_clk);
        i_cfg_we        <= 1'b0;
        model_threshold = thr;
        n_settings++;
    endtask

    // Result ready, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        out_if.ready <= !sink_hold && ($urandom_range(99) >= take_gap_pct);
    end

    // Long receiver hold-off, counted here
    initial begin : sink_backpressure
        wait (hold_trigger);
        @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (estimate_q.size() == 0) begin
                $error("unexpected result transaction: estimated_count %0d above_threshold %0b",
                       out_if.estimated_count, out_if.above_threshold);
                n_errors++;
            end else begin
                want = estimate_q.pop_front();
                if (out_if.estimated_count !== want.count) begin
                    $error("estimated_count: expected %0d, got %0d",
                           want.count, out_if.estimated_count);
                    n_errors++;
                end
                if (out_if.above_threshold !== want.above) begin
                    $error("above_threshold: expected %0b, got %0b",
                           want.above, out_if.above_threshold);
                    n_errors++;
                end
                n_checked++;
                if (want.count == COUNT_MAX)
                    n_saturated++;
                if (want.above)
                    n_above++;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_count thr;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.hash_word_0 = '0;
        in_if.hash_word_1 = '0;
        in_if.hash_word_2 = '0;
        in_if.hash_word_3 = '0;

        for (int k = 0; k < HOT_KEYS; k++)
            for (int r = 0; r < ROWS_N; r++)
                hot_slot[k][r] = SL_BITS'($urandom_range(ROW_DEPTH - 1));

        // Directed table, words listed {w3, w2, w1, w0}; threshold at reset value
        probe_tab[0]  = '{{Z, Z, Z, Z}, 1, 1};               // fresh sketch, slot zero
        probe_tab[1]  = '{{O, O, O, O}, 1, 1};               // top slot everywhere
        probe_tab[2]  = '{{Z, Z, Z, Z}, 2, 1};
        probe_tab[3]  = '{{O, O, Z, HI}, 3, 1};              // bits above the slices ignored
        probe_tab[4]  = '{{Z, Z, Z, ROW1TOP}, PREDICT, PREDICT};
        probe_tab[5]  = '{{O, Z, CHK5, FRESH}, 1, 1};        // untouched slots set minimum
        probe_tab[6]  = '{{Z, Z, Z, BIT13}, PREDICT, PREDICT};
        probe_tab[7]  = '{{Z, Z, BIT13, BIT27}, PREDICT, PREDICT};
        probe_tab[8]  = '{{O, Z, BIT27, Z}, PREDICT, PREDICT};
        probe_tab[9]  = '{{Z, O, Z, MSB}, PREDICT, PREDICT};
        probe_tab[10] = '{{CHKA, CHK5, CHKA, CHK5}, PREDICT, PREDICT};
        probe_tab[11] = '{{CHK5, CHKA, CHK5, CHKA}, PREDICT, PREDICT};
        probe_tab[12] = '{{Z, Z, MSB, O}, PREDICT, PREDICT};
        probe_tab[13] = '{{O, O, O, O}, PREDICT, PREDICT};
        probe_tab[14] = '{{Z, Z, Z, Z}, PREDICT, PREDICT};
        probe_tab[15] = '{{MSB, MSB, HI, HI}, PREDICT, PREDICT};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 23;
        take_gap_pct = 57;
        foreach (probe_tab[i])
            offer(probe_tab[i].hashes, probe_tab[i].want_count, probe_tab[i].want_above);
        settle();

        // Random phases: new threshold and idling pattern each
        for (int seg = 0; seg < SEG_N; seg++) begin
            case (seg)
                0: thr = 8'd128;
                1: thr = 8'd1;
                2: thr = t_count'($urandom_range(2, 253));
                3: thr = COUNT_MAX;
                4: thr = COUNT_MAX - 1'b1;
                default: thr = '0;
            endcase
            set_threshold(thr);
            if (seg < 2) begin
                send_gap_pct = 23;
                take_gap_pct = 57;
            end else if (seg < 4) begin
                send_gap_pct = 57;
                take_gap_pct = 23;
            end else begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            // fill the output queue behind a long receiver stall
            if (seg == 4)
                hold_trigger = 1'b1;
            repeat (SEG_ITEMS)
                offer(random_hashes(), PREDICT, PREDICT);
            settle();
        end

        $display("Run covered %0d hash transactions over %0d threshold settings, %0d checked.",
                 n_sent, n_settings, n_checked);
        $display("%0d estimates at saturation; threshold flag set %0d and clear %0d times.",
                 n_saturated, n_above, n_checked - n_above);
        if (n_errors == 0 && estimate_q.size() == 0)
            $display("count_min_sketch_counter verification clean");
        else
            $display("count_min_sketch_counter verification failed");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(LIMIT_NS);
        $display("count_min_sketch_counter verification failed");
        $finish;
    end

endmodule
